// ----- src/cbc_pkg.sv -----
// Shared types, codes and helper functions for the cartridge bank controller.
package cbc_pkg;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_ROM_RD = 3'd1;
    localparam logic [2:0] ACT_RAM_RD = 3'd2;
    localparam logic [2:0] ACT_RAM_WR = 3'd3;
    localparam logic [2:0] ACT_VALUE  = 3'd4;

    localparam logic [1:0] CFG_CART_KIND = 2'd0;
    localparam logic [1:0] CFG_ROM_SIZE  = 2'd1;
    localparam logic [1:0] CFG_RAM_SIZE  = 2'd2;

    localparam logic [2:0] RTC_SEC    = 3'd0;
    localparam logic [2:0] RTC_MIN    = 3'd1;
    localparam logic [2:0] RTC_HOUR   = 3'd2;
    localparam logic [2:0] RTC_DAY_LO = 3'd3;
    localparam logic [2:0] RTC_DAY_HI = 3'd4;

    localparam int RTC_REGS = 5;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_MBC1,
        KIND_MBC3,
        KIND_MBC5
    } kind_t;

    typedef struct packed {
        logic [7:0] cart_kind_code;
        logic [3:0] rom_size_code;
        logic [7:0] ram_size_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] bus_addr;
        logic [7:0]  bus_data;
    } item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [23:0] mem_addr;
        logic [7:0]  out_byte;
    } result_t;

    typedef struct packed {
        logic       wr;
        logic [2:0] idx;
        logic [7:0] data;
        logic       latch_wr;
        logic       tick;
    } rtc_cmd_t;

    typedef logic [RTC_REGS-1:0][7:0] rtc_regs_t;

    function automatic kind_t kind_of(input logic [7:0] code);
        kind_t k;
        k = KIND_NONE;
        if (code >= 8'h01 && code <= 8'h03)
        begin
            k = KIND_MBC1;
        end
        else if (code >= 8'h0F && code <= 8'h13)
        begin
            k = KIND_MBC3;
        end
        else if (code >= 8'h19 && code <= 8'h1E)
        begin
            k = KIND_MBC5;
        end
        return k;
    endfunction

    function automatic logic [7:0] mod60(input logic [7:0] d);
        logic [7:0] r;
        if (d >= 8'd240)
        begin
            r = d - 8'd240;
        end
        else if (d >= 8'd180)
        begin
            r = d - 8'd180;
        end
        else if (d >= 8'd120)
        begin
            r = d - 8'd120;
        end
        else if (d >= 8'd60)
        begin
            r = d - 8'd60;
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

    // The reciprocal estimate of the quotient is low by at most one, so one
    // correction step finishes the remainder.
    function automatic logic [7:0] mod24(input logic [7:0] d);
        logic [15:0] p;
        logic [3:0]  q;
        logic [7:0]  r;
        p = 16'(d) * 16'd170;
        q = p[15:12];
        r = d - 8'(q * 8'd24);
        if (r >= 8'd24)
        begin
            r = r - 8'd24;
        end
        return r;
    endfunction

endpackage

// ----- src/cbc_if.sv -----
// Valid/ready channel interfaces for bus requests and mapping results.
interface cbc_req_if;
    import cbc_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] bus_addr;
    logic [7:0]  bus_data;

    modport source (output valid, output req_type, output bus_addr, output bus_data,
                    input ready);
    modport sink (input valid, input req_type, input bus_addr, input bus_data,
                  output ready);
endinterface

interface cbc_rsp_if;
    import cbc_pkg::*;

    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [23:0] mem_addr;
    logic [7:0]  out_byte;

    modport source (output valid, output action, output mem_addr, output out_byte,
                    input ready);
    modport sink (input valid, input action, input mem_addr, input out_byte,
                  output ready);
endinterface

// ----- src/cbc_rtc.sv -----
// Real-time clock: tick divider, latch flag and the seconds, minutes, hours, day-low and day-high clock registers.
module cbc_rtc #(
    parameter int TICKS_PER_SECOND = 32768
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cbc_pkg::rtc_cmd_t cmd,
    output cbc_pkg::rtc_regs_t clock_regs
);
    import cbc_pkg::*;

    localparam int TICK_W = $clog2(TICKS_PER_SECOND);

    rtc_regs_t         clock_regs_reg;
    rtc_regs_t         clock_regs_next;
    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] tick_count_next;
    logic [7:0]        latch_last_write_reg;
    logic [7:0]        latch_last_write_next;
    logic              clock_latched_reg;
    logic              clock_latched_next;

    logic [8:0] day;
    logic       tick_wrap;

    always_comb
    begin
        clock_regs_next       = clock_regs_reg;
        tick_count_next       = tick_count_reg;
        latch_last_write_next = latch_last_write_reg;
        clock_latched_next    = clock_latched_reg;
        day                   = {clock_regs_reg[RTC_DAY_HI][0], clock_regs_reg[RTC_DAY_LO]};
        tick_wrap             = (tick_count_reg == TICK_W'(TICKS_PER_SECOND - 1));

        if (cmd.wr)
        begin
            case (cmd.idx)
                RTC_SEC:    clock_regs_next[RTC_SEC]    = mod60(cmd.data);
                RTC_MIN:    clock_regs_next[RTC_MIN]    = mod60(cmd.data);
                RTC_HOUR:   clock_regs_next[RTC_HOUR]   = mod24(cmd.data);
                RTC_DAY_LO: clock_regs_next[RTC_DAY_LO] = (cmd.data == 8'hFF) ? 8'h00 : cmd.data;
                RTC_DAY_HI: clock_regs_next[RTC_DAY_HI] = (cmd.data == 8'hFF) ? 8'h00 : cmd.data;
                default:    clock_regs_next = clock_regs_reg;
            endcase
        end

        if (cmd.latch_wr)
        begin
            if (cmd.data == 8'd1 && latch_last_write_reg == 8'd0)
            begin
                clock_latched_next = !clock_latched_reg;
            end
            latch_last_write_next = cmd.data;
        end

        // The halt bit in day-high freezes both the divider and the clock.
        if (cmd.tick && !clock_regs_reg[RTC_DAY_HI][6])
        begin
            tick_count_next = tick_wrap ? '0 : tick_count_reg + TICK_W'(1);
            if (tick_wrap && !clock_latched_reg)
            begin
                if (clock_regs_reg[RTC_SEC] == 8'd59)
                begin
                    clock_regs_next[RTC_SEC] = 8'd0;
                    if (clock_regs_reg[RTC_MIN] == 8'd59)
                    begin
                        clock_regs_next[RTC_MIN] = 8'd0;
                        if (clock_regs_reg[RTC_HOUR] == 8'd23)
                        begin
                            clock_regs_next[RTC_HOUR] = 8'd0;
                            if (day == 9'd511)
                            begin
                                day = 9'd0;
                                clock_regs_next[RTC_DAY_HI][7] = 1'b1;
                            end
                            else
                            begin
                                day = day + 9'd1;
                            end
                            clock_regs_next[RTC_DAY_LO]    = day[7:0];
                            clock_regs_next[RTC_DAY_HI][0] = day[8];
                        end
                        else
                        begin
                            clock_regs_next[RTC_HOUR] = clock_regs_reg[RTC_HOUR] + 8'd1;
                        end
                    end
                    else
                    begin
                        clock_regs_next[RTC_MIN] = clock_regs_reg[RTC_MIN] + 8'd1;
                    end
                end
                else
                begin
                    clock_regs_next[RTC_SEC] = clock_regs_reg[RTC_SEC] + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_regs_reg       <= '0;
            tick_count_reg       <= '0;
            latch_last_write_reg <= '0;
            clock_latched_reg    <= 1'b0;
        end
        else
        begin
            clock_regs_reg       <= clock_regs_next;
            tick_count_reg       <= tick_count_next;
            latch_last_write_reg <= latch_last_write_next;
            clock_latched_reg    <= clock_latched_next;
        end
    end

    assign clock_regs = clock_regs_reg;

endmodule

// ----- src/cbc_bank.sv -----
// Bank registers, address decode and physical address mapping for one word.
module cbc_bank (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  cbc_pkg::cfg_t      cfg,
    input  cbc_pkg::item_t     item,
    input  cbc_pkg::rtc_regs_t clock_regs,
    output cbc_pkg::result_t   result,
    output cbc_pkg::rtc_cmd_t  rtc_cmd
);
    import cbc_pkg::*;

    logic       ram_enable_reg;
    logic       ram_enable_next;
    logic [7:0] rom_bank_low_reg;
    logic [7:0] rom_bank_low_next;
    logic       rom_bank_high_reg;
    logic       rom_bank_high_next;
    logic [7:0] ram_bank_select_reg;
    logic [7:0] ram_bank_select_next;
    logic       banking_mode_reg;
    logic       banking_mode_next;

    kind_t       kind;
    logic [16:0] rom_mask_full;
    logic [8:0]  rom_mask;
    logic [3:0]  ram_mask;
    logic        has_ram;
    logic [8:0]  rom_lower;
    logic [8:0]  rom_upper;
    logic        ram_ok;
    logic [3:0]  ram_bank;
    logic        rtc_sel;
    logic        ram_window;
    logic [15:0] addr;
    logic [7:0]  data;

    always_comb
    begin
        kind          = kind_of(cfg.cart_kind_code);
        rom_mask_full = (17'd2 << cfg.rom_size_code) - 17'd1;
        rom_mask      = rom_mask_full[8:0];
        has_ram       = (cfg.ram_size_code >= 8'd2) && (cfg.ram_size_code <= 8'd5);
        case (cfg.ram_size_code)
            8'd3:    ram_mask = 4'd3;
            8'd4:    ram_mask = 4'd15;
            8'd5:    ram_mask = 4'd7;
            default: ram_mask = 4'd0;
        endcase

        rom_lower = '0;
        if (kind == KIND_MBC1 && banking_mode_reg)
        begin
            rom_lower = rom_mask & {2'b00, ram_bank_select_reg[1:0], 5'b00000};
        end

        case (kind)
            KIND_MBC1:
            begin
                rom_upper = {2'b00, ram_bank_select_reg[1:0], rom_bank_low_reg[4:0]};
                if (rom_bank_low_reg[4:0] == 5'd0)
                begin
                    rom_upper[0] = 1'b1;
                end
                rom_upper = rom_upper & rom_mask;
            end
            KIND_MBC3:
            begin
                rom_upper = {2'b00, rom_bank_low_reg[6:0]};
                if (rom_bank_low_reg[6:0] == 7'd0)
                begin
                    rom_upper[0] = 1'b1;
                end
                rom_upper = rom_upper & rom_mask;
            end
            KIND_MBC5:
            begin
                rom_upper = {rom_bank_high_reg, rom_bank_low_reg} & rom_mask;
            end
            default:
            begin
                rom_upper = 9'd1;
            end
        endcase

        case (kind)
            KIND_MBC1:
            begin
                ram_ok   = has_ram;
                ram_bank = banking_mode_reg ? (ram_mask & ram_bank_select_reg[3:0]) : 4'd0;
            end
            KIND_MBC3:
            begin
                ram_ok   = has_ram && (ram_bank_select_reg <= 8'd3);
                ram_bank = ram_mask & ram_bank_select_reg[3:0];
            end
            KIND_MBC5:
            begin
                ram_ok   = has_ram;
                ram_bank = ram_mask & ram_bank_select_reg[3:0];
            end
            default:
            begin
                ram_ok   = 1'b0;
                ram_bank = 4'd0;
            end
        endcase

        rtc_sel = (kind == KIND_MBC3) && (ram_bank_select_reg >= 8'd8)
                  && (ram_bank_select_reg <= 8'd12);
    end

    always_comb
    begin
        addr       = item.bus_addr;
        data       = item.bus_data;
        ram_window = (addr >= 16'hA000) && (addr <= 16'hBFFF) && ram_enable_reg;

        ram_enable_next      = ram_enable_reg;
        rom_bank_low_next    = rom_bank_low_reg;
        rom_bank_high_next   = rom_bank_high_reg;
        ram_bank_select_next = ram_bank_select_reg;
        banking_mode_next    = banking_mode_reg;

        result   = '{action: ACT_NONE, mem_addr: 24'd0, out_byte: 8'd0};
        rtc_cmd  = '{wr: 1'b0, idx: ram_bank_select_reg[2:0], data: data,
                     latch_wr: 1'b0, tick: 1'b0};

        case (item.req_type)
            REQ_READ:
            begin
                result.action   = ACT_VALUE;
                result.out_byte = 8'hFF;
                if (addr <= 16'h3FFF)
                begin
                    result.action   = ACT_ROM_RD;
                    result.out_byte = 8'd0;
                    result.mem_addr = {1'b0, rom_lower, addr[13:0]};
                end
                else if (addr <= 16'h7FFF)
                begin
                    result.action   = ACT_ROM_RD;
                    result.out_byte = 8'd0;
                    result.mem_addr = {1'b0, rom_upper, addr[13:0]};
                end
                else if (ram_window)
                begin
                    if (ram_ok)
                    begin
                        result.action   = ACT_RAM_RD;
                        result.out_byte = 8'd0;
                        result.mem_addr = {7'd0, ram_bank, addr[12:0]};
                    end
                    else if (rtc_sel)
                    begin
                        case (ram_bank_select_reg[2:0])
                            RTC_SEC:    result.out_byte = clock_regs[RTC_SEC];
                            RTC_MIN:    result.out_byte = clock_regs[RTC_MIN];
                            RTC_HOUR:   result.out_byte = clock_regs[RTC_HOUR];
                            RTC_DAY_LO: result.out_byte = clock_regs[RTC_DAY_LO];
                            RTC_DAY_HI: result.out_byte = clock_regs[RTC_DAY_HI];
                            default:    result.out_byte = 8'hFF;
                        endcase
                    end
                end
            end
            REQ_WRITE:
            begin
                if (kind != KIND_NONE)
                begin
                    if (addr <= 16'h1FFF)
                    begin
                        ram_enable_next = (data[3:0] == 4'hA);
                    end
                    else if (addr <= 16'h7FFF)
                    begin
                        case (kind)
                            KIND_MBC1:
                            begin
                                if (addr <= 16'h3FFF)
                                begin
                                    rom_bank_low_next = {3'b000, data[4:0]};
                                end
                                else if (addr <= 16'h5FFF)
                                begin
                                    ram_bank_select_next = {6'd0, data[1:0]};
                                end
                                else
                                begin
                                    banking_mode_next = data[0];
                                end
                            end
                            KIND_MBC3:
                            begin
                                if (addr <= 16'h3FFF)
                                begin
                                    rom_bank_low_next = {1'b0, data[6:0]};
                                end
                                else if (addr <= 16'h5FFF)
                                begin
                                    if (data <= 8'd3 || (data >= 8'd8 && data <= 8'd12))
                                    begin
                                        ram_bank_select_next = data;
                                    end
                                end
                                else
                                begin
                                    rtc_cmd.latch_wr = 1'b1;
                                end
                            end
                            default:
                            begin
                                if (addr <= 16'h2FFF)
                                begin
                                    rom_bank_low_next = data;
                                end
                                else if (addr <= 16'h3FFF)
                                begin
                                    rom_bank_high_next = data[0];
                                end
                                else if (addr <= 16'h5FFF)
                                begin
                                    ram_bank_select_next = data;
                                end
                            end
                        endcase
                    end
                    else if (ram_window)
                    begin
                        if (ram_ok)
                        begin
                            result.action   = ACT_RAM_WR;
                            result.mem_addr = {7'd0, ram_bank, addr[12:0]};
                            result.out_byte = data;
                        end
                        else if (rtc_sel)
                        begin
                            rtc_cmd.wr = 1'b1;
                        end
                    end
                end
            end
            REQ_TICK:
            begin
                rtc_cmd.tick = 1'b1;
            end
            default:
            begin
                result.action = ACT_NONE;
            end
        endcase

        rtc_cmd.wr       = rtc_cmd.wr && en;
        rtc_cmd.latch_wr = rtc_cmd.latch_wr && en;
        rtc_cmd.tick     = rtc_cmd.tick && en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enable_reg      <= 1'b0;
            rom_bank_low_reg    <= 8'd1;
            rom_bank_high_reg   <= 1'b0;
            ram_bank_select_reg <= 8'd0;
            banking_mode_reg    <= 1'b0;
        end
        else if (en)
        begin
            ram_enable_reg      <= ram_enable_next;
            rom_bank_low_reg    <= rom_bank_low_next;
            rom_bank_high_reg   <= rom_bank_high_next;
            ram_bank_select_reg <= ram_bank_select_next;
            banking_mode_reg    <= banking_mode_next;
        end
    end

endmodule

// ----- src/cartridge_bank_controller_core.sv -----
// Top level of the cartridge bank controller: configuration, pipeline registers and assertions.
//
// Each word on req is a CPU bus read, a bus write, one clock tick or the unused code, and each
// one yields exactly one word on rsp after it passes the input register and then
// the output register, at one word per cycle while rsp keeps taking results. A word
// first lands in an input register; the bank mapper then decodes it against the
// current bank and clock registers, updates them, and loads the result register,
// so that the next word already sees the new state. The output register lets one
// more word enter the input register while a result waits on rsp. Configuration
// writes take effect at the next edge and are meant to be made while no word is in flight.
module cartridge_bank_controller_core #(
    parameter int TICKS_PER_SECOND = 32768
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    cbc_req_if.sink    req,
    cbc_rsp_if.source  rsp
);
    import cbc_pkg::*;

    cfg_t      cfg_reg;
    logic      s1_valid_reg;
    item_t     s1_item_reg;
    logic      out_valid_reg;
    result_t   out_reg;
    logic      s1_advance;
    result_t   bank_result;
    rtc_cmd_t  rtc_cmd;
    rtc_regs_t rtc_regs;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CART_KIND: cfg_reg.cart_kind_code <= cfg_data;
                CFG_ROM_SIZE:  cfg_reg.rom_size_code  <= cfg_data[3:0];
                CFG_RAM_SIZE:  cfg_reg.ram_size_code  <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg <= '{req_type: req.req_type, bus_addr: req.bus_addr,
                             bus_data: req.bus_data};
        end
        if (s1_advance)
        begin
            out_reg <= bank_result;
        end
    end

    cbc_bank u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (s1_advance),
        .cfg        (cfg_reg),
        .item       (s1_item_reg),
        .clock_regs (rtc_regs),
        .result     (bank_result),
        .rtc_cmd    (rtc_cmd)
    );

    cbc_rtc #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_rtc (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (rtc_cmd),
        .clock_regs (rtc_regs)
    );

    assign rsp.valid    = out_valid_reg;
    assign rsp.action   = out_reg.action;
    assign rsp.mem_addr = out_reg.mem_addr;
    assign rsp.out_byte = out_reg.out_byte;

`ifndef SYNTHESIS
    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> rsp.valid)
        else $error("Processed word did not reach the output register.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg && !rsp.ready))
        else $error("Input stalled without a full pipeline.");

    a_clock_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rtc_regs[RTC_SEC] < 8'd60) && (rtc_regs[RTC_MIN] < 8'd60)
        && (rtc_regs[RTC_HOUR] < 8'd24))
        else $error("Clock register left its range.");

    a_rom_read_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.action == ACT_ROM_RD) |-> (rsp.out_byte == 8'd0))
        else $error("ROM read result carries a data byte.");
`endif

endmodule

// ----- bench/cartridge_bank_controller_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the cartridge bank controller core with a mirrored bank and clock model.
module cartridge_bank_controller_core_test;
    import cbc_pkg::*;

    localparam int SECOND_TICKS = 3;
    localparam int HOLD_CYCLES = 120;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES = 11;
    localparam int PHASE_WORDS = 130;

    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam logic [7:0] CART_ROM_ONLY = 8'h00;
    localparam logic [7:0] CART_MBC1 = 8'h01;
    localparam logic [7:0] CART_MBC1_RAM = 8'h02;
    localparam logic [7:0] CART_MBC1_LAST = 8'h03;
    localparam logic [7:0] CART_MBC3_FIRST = 8'h0F;
    localparam logic [7:0] CART_MBC3_RAM = 8'h10;
    localparam logic [7:0] CART_MBC3_LAST = 8'h13;
    localparam logic [7:0] CART_MBC5 = 8'h19;
    localparam logic [7:0] CART_MBC5_LAST = 8'h1E;
    localparam logic [7:0] CART_UNKNOWN = 8'hFF;

    localparam logic [3:0] RAM_KEY = 4'hA;
    localparam logic [7:0] LATCH_ARM = 8'h00;
    localparam logic [7:0] LATCH_FIRE = 8'h01;
    localparam logic [7:0] SEL_RAM_LAST = 8'd3;
    localparam logic [7:0] SEL_CLOCK_BASE = 8'd8;
    localparam logic [7:0] SEL_CLOCK_LAST = 8'd12;
    localparam int DAY_HALT_BIT = 6;
    localparam int DAY_CARRY_BIT = 7;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_COIN,
        FLOW_PATTERN,
        FLOW_SPARSE
    } flow_t;

    class bank_mapper_mirror;
        logic [7:0] kind_code;
        logic [3:0] rom_code;
        logic [7:0] ram_code;
        logic       ram_en;
        logic [7:0] bank_lo;
        logic       bank_hi;
        logic [7:0] ram_sel;
        logic       mode;
        logic [7:0] latch_prev;
        logic       latched;
        rtc_regs_t  rtc;
        int         tick_cnt;
        int         tick_period;
        result_t    due_answers[$];
        int         errors;
        int         answered;
        int         ticks_seen;

        function new(int period);
            tick_period = period;
            kind_code = CART_ROM_ONLY;
            rom_code = 4'd0;
            ram_code = 8'd0;
            ram_en = 1'b0;
            bank_lo = 8'd1;
            bank_hi = 1'b0;
            ram_sel = 8'd0;
            mode = 1'b0;
            latch_prev = 8'd0;
            latched = 1'b0;
            rtc = '0;
            tick_cnt = 0;
            errors = 0;
            answered = 0;
            ticks_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                CFG_CART_KIND: kind_code = value;
                CFG_ROM_SIZE: rom_code = value[3:0];
                CFG_RAM_SIZE: ram_code = value;
                default: ;
            endcase
        endfunction

        function kind_t cart_kind();
            if (kind_code >= CART_MBC1 && kind_code <= CART_MBC1_LAST)
                return KIND_MBC1;
            if (kind_code >= CART_MBC3_FIRST && kind_code <= CART_MBC3_LAST)
                return KIND_MBC3;
            if (kind_code >= CART_MBC5 && kind_code <= CART_MBC5_LAST)
                return KIND_MBC5;
            return KIND_NONE;
        endfunction

        function int unsigned rom_mask();
            return (32'd2 << rom_code) - 32'd1;
        endfunction

        function int unsigned ram_mask();
            case (ram_code)
                8'd3: return 3;
                8'd4: return 15;
                8'd5: return 7;
                default: return 0;
            endcase
        endfunction

        function int clock_wrap(logic [2:0] r);
            case (r)
                RTC_SEC, RTC_MIN: return 60;
                RTC_HOUR: return 24;
                default: return 255;
            endcase
        endfunction

        function bit clock_selected();
            return cart_kind() == KIND_MBC3 && ram_sel >= SEL_CLOCK_BASE &&
                   ram_sel <= SEL_CLOCK_LAST;
        endfunction

        function bit ram_window(kind_t k, output int unsigned bank);
            bank = 0;
            if (ram_code < 8'd2 || ram_code > 8'd5)
                return 1'b0;
            case (k)
                KIND_MBC1:
                begin
                    bank = mode ? (ram_mask() & 32'(ram_sel)) : 0;
                    return 1'b1;
                end
                KIND_MBC3:
                begin
                    if (ram_sel > SEL_RAM_LAST)
                        return 1'b0;
                    bank = ram_mask() & 32'(ram_sel);
                    return 1'b1;
                end
                KIND_MBC5:
                begin
                    bank = ram_mask() & 32'(ram_sel);
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function int unsigned lower_bank(kind_t k);
            if (k == KIND_MBC1 && mode)
                return rom_mask() & (32'(ram_sel[1:0]) << 5);
            return 0;
        endfunction

        function int unsigned upper_bank(kind_t k);
            int unsigned b;
            case (k)
                KIND_MBC1:
                begin
                    b = 32'(bank_lo[4:0]);
                    if (b == 0)
                        b = 1;
                    b = b | (32'(ram_sel[1:0]) << 5);
                end
                KIND_MBC3:
                begin
                    b = 32'(bank_lo[6:0]);
                    if (b == 0)
                        b = 1;
                end
                KIND_MBC5: b = 32'({bank_hi, bank_lo});
                default: return 1;
            endcase
            return b & rom_mask();
        endfunction

        function void advance_clock();
            int unsigned s;
            int unsigned m;
            int unsigned h;
            int unsigned day;
            if (rtc[RTC_DAY_HI][DAY_HALT_BIT])
                return;
            tick_cnt++;
            if (tick_cnt >= tick_period)
                tick_cnt = 0;
            if (latched || tick_cnt != 0)
                return;
            s = 32'(rtc[RTC_SEC]) + 1;
            m = 32'(rtc[RTC_MIN]) + s / 60;
            s = s % 60;
            h = 32'(rtc[RTC_HOUR]) + m / 60;
            m = m % 60;
            day = 32'(rtc[RTC_DAY_LO]) + (32'(rtc[RTC_DAY_HI][0]) << 8);
            day = day + h / 24;
            h = h % 24;
            if (day > 511)
            begin
                rtc[RTC_DAY_HI][DAY_CARRY_BIT] = 1'b1;
                day = day & 511;
            end
            rtc[RTC_SEC] = s[7:0];
            rtc[RTC_MIN] = m[7:0];
            rtc[RTC_HOUR] = h[7:0];
            rtc[RTC_DAY_LO] = day[7:0];
            rtc[RTC_DAY_HI][0] = day[8];
        endfunction

        function result_t map_word(item_t w);
            kind_t       k;
            int unsigned a;
            int unsigned bank;
            int unsigned maddr;
            logic [7:0]  d;
            logic [2:0]  r;
            result_t     res;
            k = cart_kind();
            a = 32'(w.bus_addr);
            d = w.bus_data;
            res.action = ACT_NONE;
            res.out_byte = 8'h00;
            maddr = 0;
            case (w.req_type)
                REQ_READ:
                begin
                    res.action = ACT_VALUE;
                    res.out_byte = 8'hFF;
                    if (a <= 'h3FFF)
                    begin
                        res.action = ACT_ROM_RD;
                        res.out_byte = 8'h00;
                        maddr = lower_bank(k) * 'h4000 + a;
                    end
                    else if (a <= 'h7FFF)
                    begin
                        res.action = ACT_ROM_RD;
                        res.out_byte = 8'h00;
                        maddr = upper_bank(k) * 'h4000 + (a - 'h4000);
                    end
                    else if (a >= 'hA000 && a <= 'hBFFF && ram_en)
                    begin
                        if (ram_window(k, bank))
                        begin
                            res.action = ACT_RAM_RD;
                            res.out_byte = 8'h00;
                            maddr = bank * 'h2000 + (a - 'hA000);
                        end
                        else if (clock_selected())
                        begin
                            r = 3'(ram_sel - SEL_CLOCK_BASE);
                            res.out_byte = rtc[r];
                        end
                    end
                end
                REQ_WRITE:
                begin
                    if (k != KIND_NONE)
                    begin
                        if (a <= 'h1FFF)
                            ram_en = (d[3:0] == RAM_KEY);
                        else if (a <= 'h7FFF)
                        begin
                            case (k)
                                KIND_MBC1:
                                begin
                                    if (a <= 'h3FFF)
                                        bank_lo = {3'b000, d[4:0]};
                                    else if (a <= 'h5FFF)
                                        ram_sel = {6'b000000, d[1:0]};
                                    else
                                        mode = d[0];
                                end
                                KIND_MBC3:
                                begin
                                    if (a <= 'h3FFF)
                                        bank_lo = {1'b0, d[6:0]};
                                    else if (a <= 'h5FFF)
                                    begin
                                        if (d <= SEL_RAM_LAST ||
                                            (d >= SEL_CLOCK_BASE && d <= SEL_CLOCK_LAST))
                                            ram_sel = d;
                                    end
                                    else
                                    begin
                                        if (d == LATCH_FIRE && latch_prev == LATCH_ARM)
                                            latched = !latched;
                                        latch_prev = d;
                                    end
                                end
                                KIND_MBC5:
                                begin
                                    if (a <= 'h2FFF)
                                        bank_lo = d;
                                    else if (a <= 'h3FFF)
                                        bank_hi = d[0];
                                    else if (a <= 'h5FFF)
                                        ram_sel = d;
                                end
                                default: ;
                            endcase
                        end
                        else if (a >= 'hA000 && a <= 'hBFFF && ram_en)
                        begin
                            if (ram_window(k, bank))
                            begin
                                res.action = ACT_RAM_WR;
                                res.out_byte = d;
                                maddr = bank * 'h2000 + (a - 'hA000);
                            end
                            else if (clock_selected())
                            begin
                                r = 3'(ram_sel - SEL_CLOCK_BASE);
                                rtc[r] = 8'(32'(d) % clock_wrap(r));
                            end
                        end
                    end
                end
                REQ_TICK:
                begin
                    ticks_seen++;
                    advance_clock();
                end
                default: ;
            endcase
            res.mem_addr = maddr[23:0];
            return res;
        endfunction

        function void take_word(item_t w);
            due_answers.push_back(map_word(w));
        endfunction

        function void match_answer(result_t got);
            result_t want;
            if (due_answers.size() == 0)
            begin
                $error("unexpected result: action %0d mem_addr %0h out_byte %0h",
                       got.action, got.mem_addr, got.out_byte);
                errors++;
                return;
            end
            want = due_answers.pop_front();
            answered++;
            if (got.action !== want.action)
            begin
                $error("action expected %0d, got %0d", want.action, got.action);
                errors++;
            end
            if (got.mem_addr !== want.mem_addr)
            begin
                $error("mem_addr expected %0h, got %0h", want.mem_addr, got.mem_addr);
                errors++;
            end
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte expected %0h, got %0h", want.out_byte, got.out_byte);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_CART_KIND;
    logic [7:0] cfg_data = 8'h00;
    bit hold_req = 1'b0;
    bit sender_steady = 1'b0;
    int burst_left = 0;
    int words_sent = 0;
    int settings_used = 0;
    int idle_cycles = 0;
    bank_mapper_mirror mirror;

    cbc_req_if req_ch ();
    cbc_rsp_if rsp_ch ();

    cartridge_bank_controller_core #(
        .TICKS_PER_SECOND(SECOND_TICKS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            mirror.match_answer({rsp_ch.action, rsp_ch.mem_addr, rsp_ch.out_byte});
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("cartridge_bank_controller_core_test failed");
                $finish;
            end
        end
    end

    initial
    begin
        flow_t      flow;
        int         span;
        logic [7:0] pattern;
        rsp_ch.ready = 1'b0;
        forever
        begin
            span = $urandom_range(16, 96);
            flow = flow_t'($urandom_range(0, 3));
            pattern = 8'($urandom);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    rsp_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (flow)
                    FLOW_FREE: rsp_ch.ready <= 1'b1;
                    FLOW_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    FLOW_PATTERN:
                    begin
                        rsp_ch.ready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                    default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic push_word(input logic [1:0] kind_req, input logic [15:0] addr,
                             input logic [7:0] data);
        item_t w;
        int    gap;
        w = {kind_req, addr, data};
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind_req;
        req_ch.bus_addr <= addr;
        req_ch.bus_data <= data;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        burst_left--;
        words_sent++;
        mirror.take_word(w);
    endtask

    task automatic drain_words();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (mirror.due_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_cart(input logic [7:0] kind_code, input logic [3:0] rom_code,
                                input logic [7:0] ram_code);
        drain_words();
        cfg_we <= 1'b1;
        cfg_index <= CFG_CART_KIND;
        cfg_data <= kind_code;
        @(posedge clk);
        cfg_index <= CFG_ROM_SIZE;
        cfg_data <= {4'h0, rom_code};
        @(posedge clk);
        cfg_index <= CFG_RAM_SIZE;
        cfg_data <= ram_code;
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror.set_reg(CFG_CART_KIND, kind_code);
        mirror.set_reg(CFG_ROM_SIZE, {4'h0, rom_code});
        mirror.set_reg(CFG_RAM_SIZE, ram_code);
        settings_used++;
    endtask

    task automatic preset_clock(input rtc_regs_t vals);
        push_word(REQ_WRITE, 16'($urandom_range(0, 'h1FFF)), {4'h0, RAM_KEY});
        for (int i = 0; i < RTC_REGS; i++)
        begin
            push_word(REQ_WRITE, 16'($urandom_range('h4000, 'h5FFF)), 8'(SEL_CLOCK_BASE + i));
            push_word(REQ_WRITE, 16'($urandom_range('hA000, 'hBFFF)), vals[i]);
        end
    endtask

    task automatic pick_setting(input int phase, output logic [7:0] kind_code,
                                output logic [3:0] rom_code, output logic [7:0] ram_code);
        case (phase)
            0: begin kind_code = CART_MBC1; rom_code = 4'd8; ram_code = 8'd3; end
            1: begin kind_code = CART_MBC3_LAST; rom_code = 4'd6; ram_code = 8'd4; end
            2: begin kind_code = CART_MBC5_LAST; rom_code = 4'd8; ram_code = 8'd5; end
            3: begin kind_code = CART_MBC3_FIRST; rom_code = 4'd0; ram_code = 8'd2; end
            4: begin kind_code = CART_MBC1_LAST; rom_code = 4'd5; ram_code = 8'hFF; end
            5: begin kind_code = CART_ROM_ONLY; rom_code = 4'd8; ram_code = 8'd0; end
            6: begin kind_code = CART_MBC5; rom_code = 4'd3; ram_code = 8'd4; end
            7: begin kind_code = CART_MBC3_RAM; rom_code = 4'd8; ram_code = 8'd3; end
            8: begin kind_code = CART_UNKNOWN; rom_code = 4'd2; ram_code = 8'd5; end
            9: begin kind_code = CART_MBC1_RAM; rom_code = 4'd6; ram_code = 8'd4; end
            default:
            begin
                kind_code = 8'($urandom);
                rom_code = 4'($urandom_range(0, 8));
                ram_code = 8'($urandom_range(0, 7));
            end
        endcase
    endtask

    function automatic logic [15:0] pick_read_addr();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 'h3FFF));
            1, 2: return 16'($urandom_range('h4000, 'h7FFF));
            3, 4: return 16'($urandom_range('hA000, 'hBFFF));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_mixed(input int count);
        int          n;
        int          pick;
        int          run;
        logic [15:0] addr;
        logic [7:0]  data;
        rtc_regs_t   vals;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                push_word(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
                n++;
            end
            else if (pick < 35)
            begin
                push_word(REQ_READ, pick_read_addr(), 8'($urandom));
                n++;
            end
            else if (pick < 62)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        addr = 16'($urandom_range(0, 'h1FFF));
                        data = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                           : {4'($urandom), RAM_KEY};
                    end
                    1:
                    begin
                        addr = 16'($urandom_range('h2000, 'h3FFF));
                        data = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 3));
                    end
                    2:
                    begin
                        addr = 16'($urandom_range('h4000, 'h5FFF));
                        case ($urandom_range(0, 2))
                            0: data = 8'($urandom_range(0, SEL_RAM_LAST));
                            1: data = 8'($urandom_range(SEL_CLOCK_BASE, SEL_CLOCK_LAST));
                            default: data = 8'($urandom);
                        endcase
                    end
                    default:
                    begin
                        addr = 16'($urandom_range('h6000, 'h7FFF));
                        data = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 1));
                    end
                endcase
                push_word(REQ_WRITE, addr, data);
                n++;
            end
            else if (pick < 76)
            begin
                push_word(REQ_WRITE, 16'($urandom_range('hA000, 'hBFFF)), 8'($urandom));
                n++;
            end
            else if (pick < 93)
            begin
                run = $urandom_range(1, 3 * SECOND_TICKS);
                repeat (run) push_word(REQ_TICK, 16'($urandom), 8'($urandom));
                n += run;
            end
            else
            begin
                vals[RTC_SEC] = $urandom_range(0, 1) ? 8'd59 : 8'($urandom);
                vals[RTC_MIN] = $urandom_range(0, 1) ? 8'd59 : 8'($urandom);
                vals[RTC_HOUR] = $urandom_range(0, 1) ? 8'd23 : 8'($urandom);
                vals[RTC_DAY_LO] = $urandom_range(0, 1) ? 8'd255 : 8'($urandom);
                case ($urandom_range(0, 3))
                    0: vals[RTC_DAY_HI] = 8'h01;
                    1: vals[RTC_DAY_HI] = 8'h81;
                    2: vals[RTC_DAY_HI] = 8'h00;
                    default: vals[RTC_DAY_HI] = 8'($urandom);
                endcase
                preset_clock(vals);
                n += 1 + 2 * RTC_REGS;
            end
        end
    endtask

    task automatic run_directed();
        // Reset setting has no controller: ROM maps straight through and writes do nothing.
        push_word(REQ_READ, 16'h0000, 8'h00);
        push_word(REQ_READ, 16'h7FFF, 8'hFF);
        push_word(REQ_WRITE, 16'h0000, {4'h0, RAM_KEY});
        push_word(REQ_READ, 16'hA000, 8'h00);
        push_word(REQ_READ, 16'hFFFF, 8'h00);
        push_word(REQ_TICK, 16'hFFFF, 8'hFF);
        push_word(REQ_SPARE, 16'hFFFF, 8'hFF);
        program_cart(CART_MBC1, 4'd6, 8'd3);
        push_word(REQ_WRITE, 16'h2000, 8'h00);
        push_word(REQ_READ, 16'h4000, 8'h00);
        push_word(REQ_WRITE, 16'h4000, 8'h03);
        push_word(REQ_WRITE, 16'h6000, 8'h01);
        push_word(REQ_READ, 16'h3FFF, 8'h00);
        push_word(REQ_WRITE, 16'h1FFF, {4'h0, RAM_KEY});
        push_word(REQ_WRITE, 16'hBFFF, 8'hFF);
        push_word(REQ_READ, 16'hA000, 8'h00);
        // Clock one second short of the day count overflowing, then halted and latched.
        program_cart(CART_MBC3_LAST, 4'd8, 8'd4);
        preset_clock({8'h01, 8'd255, 8'd23, 8'd59, 8'd59});
        repeat (SECOND_TICKS) push_word(REQ_TICK, 16'h0000, 8'h00);
        push_word(REQ_READ, 16'hB000, 8'h00);
        push_word(REQ_WRITE, 16'hA000, 8'h40);
        push_word(REQ_TICK, 16'h0000, 8'h00);
        push_word(REQ_WRITE, 16'h6000, LATCH_ARM);
        push_word(REQ_WRITE, 16'h6000, LATCH_FIRE);
        push_word(REQ_WRITE, 16'h4000, 8'h05);
        push_word(REQ_READ, 16'hA000, 8'h00);
    endtask

    initial
    begin
        logic [7:0] kind_code;
        logic [3:0] rom_code;
        logic [7:0] ram_code;
        mirror = new(SECOND_TICKS);
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_READ;
        req_ch.bus_addr = 16'h0000;
        req_ch.bus_data = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            pick_setting(phase, kind_code, rom_code, ram_code);
            program_cart(kind_code, rom_code, ram_code);
            sender_steady = (phase == 3) || ($urandom_range(0, 3) == 0);
            if (phase == 3)
                hold_req = 1'b1;
            run_mixed(PHASE_WORDS);
        end
        drain_words();
        $display("Covered %0d bus words, %0d of them clock ticks, over %0d cartridge settings.",
                 words_sent, mirror.ticks_seen, settings_used);
        $display("Compared %0d mapped results field by field; %0d mismatches.",
                 mirror.answered, mirror.errors);
        if (mirror.errors == 0 && mirror.due_answers.size() == 0)
            $display("cartridge_bank_controller_core_test passed");
        else
            $display("cartridge_bank_controller_core_test failed");
        $finish;
    end

endmodule
